FILE: rtl/gff_pkg.sv
// Shared types, constants and helper functions of the grip force feedback filter.
// No dependencies; every other file of the block but gff_if refers to it by scoped names.
package gff_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRIP_ENABLE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRIP_MODE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRIP_SCALE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KP_GAIN     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KD_GAIN     = 3'd4;

   localparam logic [30:0] SCALE_RESET = 31'd65536;

   localparam logic [4:0] SHIFT_NONE  = 5'd0;
   localparam logic [4:0] SHIFT_SCALE = 5'd16;
   localparam logic [4:0] SHIFT_GAIN  = 5'd24;
   localparam logic [4:0] SHIFT_FILT  = 5'd28;

   localparam logic [1:0] DIGIT_LAST = 2'd2;

   localparam logic signed [31:0] STIFF_LO_LIMIT = 32'sd6553;
   localparam logic signed [31:0] STIFF_HI_LIMIT = 32'sd13107;
   localparam logic signed [47:0] STIFF_HALF     = 48'sd32768;
   localparam logic [18:0]        STIFF_NUM      = 19'd262144;
   localparam logic [5:0]         KG_HIGH        = 6'd40;
   localparam logic [5:0]         KG_LOW         = 6'd20;
   localparam logic [2:0]         DIV_LAST_STEP  = 3'd5;

   localparam logic signed [63:0] SAT32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] SAT32_MAX = 64'sd2147483647;
   localparam logic signed [63:0] SAT48_MIN = 64'shFFFF_8000_0000_0000;
   localparam logic signed [63:0] SAT48_MAX = 64'sh0000_7FFF_FFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_ISSUE,
      ST_WAIT,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      PH_SCALE_A,
      PH_SCALE_V,
      PH_FILT_E,
      PH_FILT_V,
      PH_GAIN_P,
      PH_GAIN_D,
      PH_STIFF
   } phase_type;

   typedef struct packed {
      logic               start;
      logic signed [47:0] a;
      logic signed [31:0] b;
      logic [4:0]         shift;
   } mul_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] result;
   } mul_rsp_type;

   function automatic logic signed [31:0] coef_b(input logic [2:0] idx);
      logic signed [31:0] c;
      unique case (idx)
         3'd0, 3'd3: c = 32'sd58948;
         3'd1, 3'd2: c = 32'sd176845;
         default:    c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [31:0] coef_a(input logic [2:0] idx);
      logic signed [31:0] c;
      unique case (idx)
         3'd1:    c = 32'sd737875381;
         3'd2:    c = -32'sd678658520;
         3'd3:    c = 32'sd208735411;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v < SAT32_MIN) return 32'sh8000_0000;
      else if (v > SAT32_MAX) return 32'sh7FFF_FFFF;
      else return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
      if (v < SAT48_MIN) return 48'sh8000_0000_0000;
      else if (v > SAT48_MAX) return 48'sh7FFF_FFFF_FFFF;
      else return v[47:0];
   endfunction

   function automatic logic signed [47:0] x256(input logic signed [31:0] x);
      return {{8{x[31]}}, x, 8'h00};
   endfunction

   function automatic logic [30:0] force_clamp(input logic signed [63:0] v);
      if (v < 64'sd0) return '0;
      else if (v > SAT32_MAX) return '1;
      else return v[30:0];
   endfunction

endpackage

FILE: rtl/gff_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on nothing; used by the grip force feedback filter top level.
interface gff_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] grip_angle;
   logic signed [31:0] grip_velocity;
   logic signed [31:0] slave_grasp;

   modport source (output valid, grip_angle, grip_velocity, slave_grasp, input ready);
   modport sink (input valid, grip_angle, grip_velocity, slave_grasp, output ready);
endinterface

interface gff_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] grip_force;

   modport source (output valid, grip_force, input ready);
   modport sink (input valid, grip_force, output ready);
endinterface

FILE: rtl/grip_force_feedback_filter.sv
// Grip force feedback filter: one request beat (master angle, velocity, slave
// grasp, all Q16.16) gives one response beat with the gripper force command.
// Depends on gff_pkg, gff_if and gff_mul.
//
// Usage: write the csr_ registers while idle, then send request beats. The
// block takes one beat at a time; req.ready is high only while it is idle.
// All products go through one shared multiplier. When disabled, the block answers
// with force zero and uses no multiplier; mode 1 needs one stiffness product,
// after a divide when the angle lies above STIFF_LO_LIMIT and at most
// STIFF_HI_LIMIT; mode 0 scales, filters both signals and applies the gains.
// The first enabled mode 0 beat after reset seeds both filter histories with itself.
// Reset clears the registers to their defaults and the filter to unseeded.
// If the receiver stalls, the response beat holds and no request is taken
// until it is accepted.
module grip_force_feedback_filter #(
   parameter int FILTER_TAPS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   gff_req_if.sink                          req,
   gff_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [gff_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gff_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int HIST = (FILTER_TAPS > 2) ? FILTER_TAPS - 1 : 2;
   localparam int HW   = $clog2(HIST);
   localparam int TW   = $clog2(FILTER_TAPS);

   logic               enable_ff;
   logic               mode_ff;
   logic [30:0]        scale_ff;
   logic signed [31:0] kp_ff;
   logic signed [31:0] kd_ff;

   gff_pkg::state_type state_ff, state_in;
   gff_pkg::phase_type phase_ff, phase_in;
   logic [TW-1:0]      tap_ff, tap_in;
   logic               sub_ff, sub_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [31:0] grasp_ff, grasp_in;
   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] nv_ff, nv_in;
   logic               primed_ff, primed_in;
   logic [18:0]        rem_ff, rem_in;
   logic [5:0]         quo_ff, quo_in;
   logic [2:0]         dcnt_ff, dcnt_in;
   logic [5:0]         kg_ff, kg_in;

   logic signed [31:0] exh_ff [HIST];
   logic signed [31:0] exh_in [HIST];
   logic signed [47:0] eyh_ff [HIST];
   logic signed [47:0] eyh_in [HIST];
   logic signed [31:0] vxh_ff [HIST];
   logic signed [31:0] vxh_in [HIST];
   logic signed [47:0] vyh_ff [HIST];
   logic signed [47:0] vyh_in [HIST];

   gff_pkg::mul_req_type mul_req;
   gff_pkg::mul_rsp_type mul_rsp;

   logic               accept;
   logic               last_term;
   logic [TW-1:0]      tap_m1;
   logic [HW-1:0]      hist_idx;
   logic [2:0]         coef_idx;
   logic signed [31:0] x_cur;
   logic signed [31:0] xh_sel;
   logic signed [47:0] yh_sel;
   logic [19:0]        div_shifted;
   logic signed [47:0] y_new;
   logic signed [31:0] nv_val;

   gff_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         mode_ff   <= 1'b0;
         scale_ff  <= gff_pkg::SCALE_RESET;
         kp_ff     <= '0;
         kd_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            gff_pkg::CSR_GRIP_ENABLE: enable_ff <= csr_wdata[0];
            gff_pkg::CSR_GRIP_MODE:   mode_ff   <= csr_wdata[0];
            gff_pkg::CSR_GRIP_SCALE:  scale_ff  <= csr_wdata[30:0];
            gff_pkg::CSR_KP_GAIN:     kp_ff     <= csr_wdata;
            gff_pkg::CSR_KD_GAIN:     kd_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept    = req.valid && req.ready;
   assign last_term = (tap_ff == TW'(FILTER_TAPS - 1)) && sub_ff;
   assign tap_m1    = tap_ff - TW'(1);
   assign hist_idx  = tap_m1[HW-1:0];
   assign coef_idx  = 3'(tap_ff);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gff_pkg::ST_IDLE: begin
            if (accept) begin
               if (!enable_ff) state_in = gff_pkg::ST_DONE;
               else if (mode_ff && req.grip_angle > gff_pkg::STIFF_LO_LIMIT &&
                        req.grip_angle <= gff_pkg::STIFF_HI_LIMIT)
                  state_in = gff_pkg::ST_DIVIDE;
               else state_in = gff_pkg::ST_ISSUE;
            end
         end
         gff_pkg::ST_DIVIDE: begin
            if (dcnt_ff == '0) state_in = gff_pkg::ST_ISSUE;
         end
         gff_pkg::ST_ISSUE: state_in = gff_pkg::ST_WAIT;
         gff_pkg::ST_WAIT: begin
            if (mul_rsp.done) begin
               unique case (phase_ff)
                  gff_pkg::PH_FILT_E, gff_pkg::PH_FILT_V:
                     state_in = last_term ? gff_pkg::ST_UPDATE : gff_pkg::ST_ISSUE;
                  gff_pkg::PH_GAIN_D, gff_pkg::PH_STIFF: state_in = gff_pkg::ST_DONE;
                  default: state_in = gff_pkg::ST_ISSUE;
               endcase
            end
         end
         gff_pkg::ST_UPDATE: state_in = gff_pkg::ST_ISSUE;
         gff_pkg::ST_DONE: begin
            if (rsp.ready) state_in = gff_pkg::ST_IDLE;
         end
         default: state_in = gff_pkg::ST_IDLE;
      endcase
   end

   // Outputs and multiplier operands
   always_comb begin
      x_cur  = (phase_ff == gff_pkg::PH_FILT_V) ? nv_ff : err_ff;
      xh_sel = (phase_ff == gff_pkg::PH_FILT_V) ? vxh_ff[hist_idx] : exh_ff[hist_idx];
      yh_sel = (phase_ff == gff_pkg::PH_FILT_V) ? vyh_ff[hist_idx] : eyh_ff[hist_idx];

      req.ready      = (state_ff == gff_pkg::ST_IDLE);
      rsp.valid      = (state_ff == gff_pkg::ST_DONE);
      rsp.grip_force = gff_pkg::force_clamp(acc_ff);

      mul_req.start = (state_ff == gff_pkg::ST_ISSUE);
      mul_req.a     = 48'(angle_ff);
      mul_req.b     = {1'b0, scale_ff};
      mul_req.shift = gff_pkg::SHIFT_SCALE;
      unique case (phase_ff)
         gff_pkg::PH_SCALE_A: mul_req.a = 48'(angle_ff);
         gff_pkg::PH_SCALE_V: mul_req.a = 48'(vel_ff);
         gff_pkg::PH_FILT_E, gff_pkg::PH_FILT_V: begin
            mul_req.shift = gff_pkg::SHIFT_FILT;
            if (tap_ff == '0) begin
               mul_req.a = gff_pkg::x256(x_cur);
               mul_req.b = gff_pkg::coef_b(coef_idx);
            end else if (!sub_ff) begin
               mul_req.a = gff_pkg::x256(xh_sel);
               mul_req.b = gff_pkg::coef_b(coef_idx);
            end else begin
               mul_req.a = yh_sel;
               mul_req.b = gff_pkg::coef_a(coef_idx);
            end
         end
         gff_pkg::PH_GAIN_P: begin
            mul_req.a     = eyh_ff[0];
            mul_req.b     = kp_ff;
            mul_req.shift = gff_pkg::SHIFT_GAIN;
         end
         gff_pkg::PH_GAIN_D: begin
            mul_req.a     = vyh_ff[0];
            mul_req.b     = kd_ff;
            mul_req.shift = gff_pkg::SHIFT_GAIN;
         end
         gff_pkg::PH_STIFF: begin
            mul_req.a     = gff_pkg::STIFF_HALF - 48'(angle_ff);
            mul_req.b     = 32'(kg_ff);
            mul_req.shift = gff_pkg::SHIFT_NONE;
         end
         default: ;
      endcase
   end

   // Datapath
   always_comb begin
      phase_in  = phase_ff;
      tap_in    = tap_ff;
      sub_in    = sub_ff;
      acc_in    = acc_ff;
      angle_in  = angle_ff;
      vel_in    = vel_ff;
      grasp_in  = grasp_ff;
      err_in    = err_ff;
      nv_in     = nv_ff;
      primed_in = primed_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      kg_in     = kg_ff;
      exh_in    = exh_ff;
      eyh_in    = eyh_ff;
      vxh_in    = vxh_ff;
      vyh_in    = vyh_ff;

      div_shifted = 20'(angle_ff[13:0]) << dcnt_ff;
      y_new       = gff_pkg::sat48(acc_ff);
      nv_val      = gff_pkg::sat32(-64'(gff_pkg::sat32(mul_rsp.result)));

      unique case (state_ff)
         gff_pkg::ST_IDLE: begin
            if (accept) begin
               angle_in = req.grip_angle;
               vel_in   = req.grip_velocity;
               grasp_in = req.slave_grasp;
               acc_in   = '0;
               phase_in = mode_ff ? gff_pkg::PH_STIFF : gff_pkg::PH_SCALE_A;
               kg_in    = (req.grip_angle <= gff_pkg::STIFF_LO_LIMIT) ?
                          gff_pkg::KG_HIGH : gff_pkg::KG_LOW;
               rem_in   = gff_pkg::STIFF_NUM;
               quo_in   = '0;
               dcnt_in  = gff_pkg::DIV_LAST_STEP;
            end
         end
         gff_pkg::ST_DIVIDE: begin
            if (20'(rem_ff) >= div_shifted) begin
               rem_in          = rem_ff - div_shifted[18:0];
               quo_in[dcnt_ff] = 1'b1;
            end
            dcnt_in = dcnt_ff - 3'd1;
            if (dcnt_ff == '0) kg_in = quo_in;
         end
         gff_pkg::ST_WAIT: begin
            if (mul_rsp.done) begin
               unique case (phase_ff)
                  gff_pkg::PH_SCALE_A: begin
                     err_in   = gff_pkg::sat32(64'(grasp_ff) -
                                               64'(gff_pkg::sat32(mul_rsp.result)));
                     phase_in = gff_pkg::PH_SCALE_V;
                  end
                  gff_pkg::PH_SCALE_V: begin
                     nv_in    = nv_val;
                     phase_in = gff_pkg::PH_FILT_E;
                     tap_in   = '0;
                     sub_in   = 1'b0;
                     if (!primed_ff) begin
                        for (int i = 0; i < HIST; i++) begin
                           exh_in[i] = err_ff;
                           eyh_in[i] = gff_pkg::x256(err_ff);
                           vxh_in[i] = nv_val;
                           vyh_in[i] = gff_pkg::x256(nv_val);
                        end
                        primed_in = 1'b1;
                     end
                  end
                  gff_pkg::PH_FILT_E, gff_pkg::PH_FILT_V: begin
                     acc_in = ((tap_ff == '0) ? 64'sd0 : acc_ff) + mul_rsp.result;
                     if (tap_ff == '0 || sub_ff) begin
                        if (!last_term) tap_in = tap_ff + TW'(1);
                        sub_in = 1'b0;
                     end else begin
                        sub_in = 1'b1;
                     end
                  end
                  gff_pkg::PH_GAIN_P: begin
                     acc_in   = mul_rsp.result;
                     phase_in = gff_pkg::PH_GAIN_D;
                  end
                  gff_pkg::PH_GAIN_D: acc_in = acc_ff + mul_rsp.result;
                  gff_pkg::PH_STIFF:  acc_in = mul_rsp.result;
                  default: ;
               endcase
            end
         end
         gff_pkg::ST_UPDATE: begin
            if (phase_ff == gff_pkg::PH_FILT_E) begin
               for (int i = HIST - 1; i > 0; i--) begin
                  exh_in[i] = exh_ff[i-1];
                  eyh_in[i] = eyh_ff[i-1];
               end
               exh_in[0] = err_ff;
               eyh_in[0] = y_new;
               phase_in  = gff_pkg::PH_FILT_V;
            end else begin
               for (int i = HIST - 1; i > 0; i--) begin
                  vxh_in[i] = vxh_ff[i-1];
                  vyh_in[i] = vyh_ff[i-1];
               end
               vxh_in[0] = nv_ff;
               vyh_in[0] = y_new;
               phase_in  = gff_pkg::PH_GAIN_P;
            end
            tap_in = '0;
            sub_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gff_pkg::ST_IDLE;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         primed_ff <= primed_in;
      end
      phase_ff <= phase_in;
      tap_ff   <= tap_in;
      sub_ff   <= sub_in;
      acc_ff   <= acc_in;
      angle_ff <= angle_in;
      vel_ff   <= vel_in;
      grasp_ff <= grasp_in;
      err_ff   <= err_in;
      nv_ff    <= nv_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dcnt_ff  <= dcnt_in;
      kg_ff    <= kg_in;
      exh_ff   <= exh_in;
      eyh_ff   <= eyh_in;
      vxh_ff   <= vxh_in;
      vyh_ff   <= vyh_in;
   end

   a_idle_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid)
      else $error("response valid while taking requests");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req.ready)
      else $error("request taken while busy");

   a_mul_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == gff_pkg::ST_WAIT))
      else $error("multiplier result outside wait state");

   a_primed_holds: assert property (@(posedge clock) disable iff (reset)
      !$fell(primed_ff))
      else $error("filter seed flag dropped");

endmodule

FILE: rtl/gff_mul.sv
// Shared signed multiplier: 48 x 32 bits, one 16-bit digit of a per cycle,
// then an arithmetic right shift. Depends on gff_pkg.
module gff_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  gff_pkg::mul_req_type mul_req,
   output gff_pkg::mul_rsp_type mul_rsp
);

   logic               busy_ff, busy_in;
   logic [1:0]         digit_ff, digit_in;
   logic signed [47:0] a_ff, a_in;
   logic signed [31:0] b_ff, b_in;
   logic [4:0]         shift_ff, shift_in;
   logic signed [79:0] acc_ff, acc_in;
   logic               done_ff, done_in;
   logic signed [63:0] result_ff, result_in;

   logic signed [16:0] dig;
   logic signed [48:0] part;
   logic signed [79:0] part_ext;
   logic signed [79:0] part_pos;
   logic signed [79:0] acc_sum;
   logic signed [79:0] acc_shr;

   always_comb begin
      unique case (digit_ff)
         2'd0:    dig = {1'b0, a_ff[15:0]};
         2'd1:    dig = {1'b0, a_ff[31:16]};
         2'd2:    dig = {a_ff[47], a_ff[47:32]};
         default: dig = '0;
      endcase
      part     = dig * b_ff;
      part_ext = 80'(part);
      unique case (digit_ff)
         2'd0:    part_pos = part_ext;
         2'd1:    part_pos = part_ext <<< 16;
         2'd2:    part_pos = part_ext <<< 32;
         default: part_pos = '0;
      endcase
      acc_sum = acc_ff + part_pos;
      acc_shr = acc_sum >>> shift_ff;
   end

   always_comb begin
      busy_in   = busy_ff;
      digit_in  = digit_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      shift_in  = shift_ff;
      acc_in    = acc_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (mul_req.start) begin
         busy_in  = 1'b1;
         digit_in = '0;
         a_in     = mul_req.a;
         b_in     = mul_req.b;
         shift_in = mul_req.shift;
         acc_in   = '0;
      end else if (busy_ff) begin
         acc_in   = acc_sum;
         digit_in = digit_ff + 2'd1;
         if (digit_ff == gff_pkg::DIGIT_LAST) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = acc_shr[63:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      digit_ff  <= digit_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      shift_ff  <= shift_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
   end

   assign mul_rsp.done   = done_ff;
   assign mul_rsp.result = result_ff;

endmodule

FILE: test/grip_force_feedback_filter_tb.sv
// Testbench for grip_force_feedback_filter: directed and random request beats
// checked against an in-bench force predictor. Depends on gff_pkg, gff_if and grip_force_feedback_filter.
module grip_force_feedback_filter_tb;

   localparam int unsigned CYCLE_LIMIT = 3000000;

   logic clock;
   logic reset;
   logic csr_we;
   logic [gff_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [gff_pkg::CSR_DATA_W-1:0]  csr_wdata;

   gff_req_if req_if ();
   gff_rsp_if rsp_if ();

   grip_force_feedback_filter u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of the registers and filter state
   logic        enable_q;
   logic        mode_q;
   longint      scale_q;
   longint      kp_q;
   longint      kd_q;
   logic        seeded;
   longint      err_x[3];
   longint      err_y[3];
   longint      vel_x[3];
   longint      vel_y[3];

   logic [30:0] force_queue[$];
   int          fail_count;
   int unsigned cycle_count;
   int          req_idle_pct;
   int          rsp_idle_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sat_word(longint v);
      return clamp(v, -64'sd2147483648, 64'sd2147483647);
   endfunction

   function automatic longint coef_product(longint y, longint c, int s);
      logic signed [127:0] yw;
      logic signed [127:0] cw;
      logic signed [127:0] p;
      yw = y;
      cw = c;
      p = (yw * cw) >>> s;
      return p[63:0];
   endfunction

   function automatic longint lowpass(longint x, ref longint xh[3], ref longint yh[3]);
      longint acc;
      acc = coef_product(x * 256, 58948, 28);
      acc += coef_product(xh[0] * 256, 176845, 28) + coef_product(yh[0], 737875381, 28);
      acc += coef_product(xh[1] * 256, 176845, 28) + coef_product(yh[1], -678658520, 28);
      acc += coef_product(xh[2] * 256, 58948, 28) + coef_product(yh[2], 208735411, 28);
      acc = clamp(acc, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
      xh[2] = xh[1]; yh[2] = yh[1];
      xh[1] = xh[0]; yh[1] = yh[0];
      xh[0] = x;     yh[0] = acc;
      return acc;
   endfunction

   function automatic logic [30:0] predict_force(logic signed [31:0] angle,
                                                 logic signed [31:0] vel,
                                                 logic signed [31:0] grasp);
      longint a, f, kg, sa, sv, err, nv, fe, fv;
      a = angle;
      f = 0;
      if (enable_q) begin
         if (mode_q) begin
            if (a * 10 < 65536) kg = 40;
            else if (a * 10 < 131072) kg = 262144 / a;
            else kg = 20;
            f = (32768 - a) * kg;
         end else begin
            sa = sat_word((a * scale_q) >>> 16);
            sv = sat_word((longint'(vel) * scale_q) >>> 16);
            err = sat_word(longint'(grasp) - sa);
            nv = sat_word(-sv);
            if (!seeded) begin
               for (int i = 0; i < 3; i++) begin
                  err_x[i] = err; err_y[i] = err * 256;
                  vel_x[i] = nv;  vel_y[i] = nv * 256;
               end
               seeded = 1'b1;
            end
            fe = lowpass(err, err_x, err_y);
            fv = lowpass(nv, vel_x, vel_y);
            f = coef_product(fe, kp_q, 24) + coef_product(fv, kd_q, 24);
         end
      end
      f = clamp(f, 0, 64'sd2147483647);
      return f[30:0];
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] v;
      case ($urandom_range(0, 6))
         0: v = 32'h8000_0000;
         1: v = 32'h7FFF_FFFF;
         2: v = 32'h0;
         3: v = $urandom_range(0, 262144) - 131072;
         4: v = $urandom_range(0, 8388608) - 4194304;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // response checker and receiver stalls
   always @(posedge clock) begin
      logic [30:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (force_queue.size() == 0) begin
            $error("grip_force: no beat expected, actual %0d", rsp_if.grip_force);
            fail_count++;
         end else begin
            want = force_queue.pop_front();
            if (rsp_if.grip_force !== want) begin
               $error("grip_force: expected %0d, actual %0d", want, rsp_if.grip_force);
               fail_count++;
            end
         end
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   task automatic send_beat(logic [31:0] angle, logic [31:0] vel, logic [31:0] grasp);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.grip_angle    <= angle;
      req_if.grip_velocity <= vel;
      req_if.slave_grasp   <= grasp;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      force_queue.push_back(predict_force(angle, vel, grasp));
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (force_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(logic [gff_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         gff_pkg::CSR_GRIP_ENABLE: enable_q = value[0];
         gff_pkg::CSR_GRIP_MODE:   mode_q = value[0];
         gff_pkg::CSR_GRIP_SCALE:  scale_q = longint'(value[30:0]);
         gff_pkg::CSR_KP_GAIN:     kp_q = longint'(signed'(value));
         gff_pkg::CSR_KD_GAIN:     kd_q = longint'(signed'(value));
         default: ;
      endcase
   endtask

   task automatic configure(logic en, logic md, logic [31:0] sc, logic [31:0] kp,
                            logic [31:0] kd);
      drain();
      write_reg(gff_pkg::CSR_GRIP_ENABLE, {31'd0, en});
      write_reg(gff_pkg::CSR_GRIP_MODE, {31'd0, md});
      write_reg(gff_pkg::CSR_GRIP_SCALE, sc);
      write_reg(gff_pkg::CSR_KP_GAIN, kp);
      write_reg(gff_pkg::CSR_KD_GAIN, kd);
   endtask

   task automatic test_disabled();
      send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      configure(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(32'h0001_0000, 32'h0, 32'h0002_0000);
   endtask

   task automatic test_filter_directed();
      // first enabled mode 0 beat seeds the histories
      configure(1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000);
      send_beat(32'h0000_4000, 32'h0001_0000, 32'h0002_0000);
      send_beat(32'h0000_8000, 32'hFFFF_0000, 32'h0001_0000);
      send_beat(32'h0, 32'h0, 32'h0);
      // drive the scaling and error to saturation
      configure(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_beat(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      configure(1'b1, 1'b0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_beat(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF);
   endtask

   task automatic test_stiffness_directed();
      configure(1'b1, 1'b1, 32'h0001_0000, 32'h0, 32'h0);
      send_beat(32'h8000_0000, 32'h0, 32'h0);
      send_beat(32'hFFFF_FFFF, 32'h0, 32'h0);
      send_beat(32'd6553, 32'h0, 32'h0);
      send_beat(32'd6554, 32'h0, 32'h0);
      send_beat(32'd10000, 32'h0, 32'h0);
      send_beat(32'd13107, 32'h0, 32'h0);
      send_beat(32'd13108, 32'h0, 32'h0);
      send_beat(32'd32768, 32'h0, 32'h0);
      send_beat(32'd40000, 32'h0, 32'h0);
      send_beat(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(int count);
      logic [31:0] angle;
      for (int n = 0; n < count; n++) begin
         if (n % 80 == 0)
            configure($urandom_range(0, 7) != 0, $urandom_range(0, 2) == 0,
                      ($urandom_range(0, 2) == 0) ? 32'h0001_0000 : pick_word(),
                      pick_word(), pick_word());
         if (mode_q && $urandom_range(0, 1))
            angle = $urandom_range(0, 20000) - 2000;
         else
            angle = pick_word();
         send_beat(angle, pick_word(), pick_word());
      end
   endtask

   initial begin
      fail_count = 0;
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      req_if.valid <= 1'b0;
      req_if.grip_angle <= '0;
      req_if.grip_velocity <= '0;
      req_if.slave_grasp <= '0;
      enable_q = 1'b0;
      mode_q = 1'b0;
      scale_q = 65536;
      kp_q = 0;
      kd_q = 0;
      seeded = 1'b0;
      for (int i = 0; i < 3; i++) begin
         err_x[i] = 0; err_y[i] = 0; vel_x[i] = 0; vel_y[i] = 0;
      end
      req_idle_pct = 17;
      rsp_idle_pct = 49;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_disabled();
      test_filter_directed();
      test_stiffness_directed();
      test_random(660);
      req_idle_pct = 49;
      rsp_idle_pct = 17;
      test_random(660);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      test_random(660);

      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
